@@ rtl/core/spv_pkg.sv @@
// ----------------------------------------------------------------------------
// spv_pkg
// Shared types, codes and constants for the sample playback voice core.
// ----------------------------------------------------------------------------
package spv_pkg;

    // Default sample memory depth in entries.
    localparam int SAMPLE_DEPTH_DEF = 65536;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_INDEX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_INDEX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_BACKWARD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LEVEL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN_POSITION  = 3'd6;

    // Register reset values.
    localparam logic [23:0] STEP_SIZE_RST    = 24'd65536;
    localparam logic [15:0] OUTPUT_LEVEL_RST = 16'd32768;
    localparam logic [15:0] PAN_POSITION_RST = 16'd16384;

    // Q1.15 unity gain.
    localparam logic [15:0] UNITY_Q15 = 16'd32768;

    // Request opcodes.
    typedef enum logic [1:0] {
        OP_WRITE    = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2,
        OP_TICK     = 2'd3
    } opcode_t;

    // One request on the command channel.
    typedef struct packed {
        opcode_t            opcode;
        logic [15:0]        write_address;
        logic signed [15:0] write_sample;
        logic [15:0]        note_velocity;
        logic [15:0]        envelope_value;
    } cmd_item_t;

    // One item on the result channel.
    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic               voice_active;
    } res_item_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_A,
        ST_READ_B,
        ST_INTERP,
        ST_SCALE,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic read_a;
        logic read_b;
        logic interp;
        logic scale;
        logic commit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic tick_live;
    } dp_stat_t;

endpackage

@@ rtl/core/sample_playback_voice_core.sv @@
// ----------------------------------------------------------------------------
// sample_playback_voice_core: one-voice linear interpolating sample player.
// A playing tick is captured, read from the single-port sample memory twice
// in sequence, interpolated, scaled and committed; any other request goes from
// capture to commit. No new request is taken until the last one is committed.
// Reset clears voice state and the configuration registers at once; the sample memory is not cleared.
// ----------------------------------------------------------------------------
module sample_playback_voice_core #(
    parameter int SAMPLE_DEPTH = spv_pkg::SAMPLE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    output logic                           cmd_stall,
    input  spv_pkg::cmd_item_t             cmd_data,
    output logic                           res_valid,
    input  logic                           res_stall,
    output spv_pkg::res_item_t             res_data,
    input  logic                           cfg_wr_en,
    input  logic [spv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spv_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    spv_pkg::dp_cmd_t  dp_cmd;
    spv_pkg::dp_stat_t dp_stat;

    // Sequencer.
    spv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .dp_stat   (dp_stat),
        .dp_cmd    (dp_cmd)
    );

    // Datapath with sample memory.
    spv_datapath #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_data  (cmd_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat),
        .res_data  (res_data)
    );

`ifndef NO_ASSERTIONS
    // A commit never overwrites a result that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.commit |-> (!res_valid || !res_stall))
        else $error("result overwritten while stalled");

    // At most one datapath step runs in a cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({dp_cmd.capture, dp_cmd.read_a, dp_cmd.read_b,
                  dp_cmd.interp, dp_cmd.scale, dp_cmd.commit}))
        else $error("overlapping datapath commands");

    // The second memory read follows the first directly.
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.read_a |=> dp_cmd.read_b)
        else $error("second sample read missing");

    // An accepted request keeps the block busy for the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("request taken while busy");
`endif

endmodule

@@ rtl/core/spv_ctrl.sv @@
// ----------------------------------------------------------------------------
// spv_ctrl
// Sequencer for the voice: steps a tick through its memory reads and
// arithmetic stages and owns the result channel valid flag.
// ----------------------------------------------------------------------------
module spv_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    output logic              res_valid,
    input  logic              res_stall,
    input  spv_pkg::dp_stat_t dp_stat,
    output spv_pkg::dp_cmd_t  dp_cmd
);

    spv_pkg::state_t state_reg;
    spv_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    // State and result valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spv_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The result register is free when empty or being taken this cycle.
    assign out_free = !out_valid_reg || !res_stall;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        case (state_reg)
            spv_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    dp_cmd.capture = 1'b1;
                    state_next     = dp_stat.tick_live ? spv_pkg::ST_READ_A
                                                       : spv_pkg::ST_FINISH;
                end
            end
            spv_pkg::ST_READ_A:
            begin
                dp_cmd.read_a = 1'b1;
                state_next    = spv_pkg::ST_READ_B;
            end
            spv_pkg::ST_READ_B:
            begin
                dp_cmd.read_b = 1'b1;
                state_next    = spv_pkg::ST_INTERP;
            end
            spv_pkg::ST_INTERP:
            begin
                dp_cmd.interp = 1'b1;
                state_next    = spv_pkg::ST_SCALE;
            end
            spv_pkg::ST_SCALE:
            begin
                dp_cmd.scale = 1'b1;
                state_next   = spv_pkg::ST_FINISH;
            end
            spv_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    dp_cmd.commit = 1'b1;
                    state_next    = spv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spv_pkg::ST_IDLE;
            end
        endcase
    end

    // A committed request fills the result register; a taken one empties it.
    assign out_valid_next = dp_cmd.commit || (out_valid_reg && res_stall);

    assign cmd_stall = (state_reg != spv_pkg::ST_IDLE);
    assign res_valid = out_valid_reg;

endmodule

@@ rtl/core/spv_datapath.sv @@
// ----------------------------------------------------------------------------
// spv_datapath
// Sample memory, configuration registers, voice state, interpolation and
// gain arithmetic, and the result register.
// ----------------------------------------------------------------------------
module spv_datapath #(
    parameter int SAMPLE_DEPTH = spv_pkg::SAMPLE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  spv_pkg::cmd_item_t               cmd_data,
    input  logic                             cfg_wr_en,
    input  logic [spv_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spv_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  spv_pkg::dp_cmd_t                 dp_cmd,
    output spv_pkg::dp_stat_t                dp_stat,
    output spv_pkg::res_item_t               res_data
);

    localparam int          AW      = $clog2(SAMPLE_DEPTH);
    localparam logic [31:0] DEPTH_W = 32'(SAMPLE_DEPTH);

    // Saturate a scaled sample to the signed 16-bit range.
    function automatic logic signed [15:0] sat16(input logic signed [20:0] x);
        logic signed [15:0] r;
        if (x > 21'sd32767)
            r = 16'sh7FFF;
        else if (x < -21'sd32768)
            r = 16'sh8000;
        else
            r = x[15:0];
        return r;
    endfunction

    // Configuration registers.
    logic [16:0] count_reg;
    logic [15:0] start_reg;
    logic [15:0] end_reg;
    logic [23:0] step_reg;
    logic        backward_reg;
    logic [15:0] level_reg;
    logic [15:0] pan_reg;

    // Captured request.
    spv_pkg::opcode_t   op_reg;
    logic [15:0]        waddr_reg;
    logic signed [15:0] wsample_reg;
    logic [15:0]        vel_in_reg;
    logic [15:0]        env_reg;
    logic               live_reg;

    // Voice state.
    logic [31:0] pos_reg;
    logic [31:0] pos_next;
    logic        playing_reg;
    logic        playing_next;
    logic [15:0] vel_hold_reg;
    logic [15:0] vel_next;

    // Sample memory.
    logic signed [15:0] sample_mem [SAMPLE_DEPTH];
    logic signed [15:0] rd_data_reg;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic [31:0]        wr_addr_w;
    logic               wr_ok;
    logic               mem_we;

    // Read index arithmetic.
    logic [31:0] count_ext;
    logic [31:0] count_eff;
    logic [31:0] last_w;
    logic [15:0] last_idx;
    logic [15:0] idx_raw;
    logic        beyond;
    logic [15:0] rd_idx;
    logic [15:0] rd_frac;
    logic [31:0] addr_a_w;
    logic [31:0] addr_b_w;
    logic [15:0] idx_reg;
    logic [15:0] frac_reg;
    logic        at_last_reg;

    // Interpolation.
    logic signed [15:0] a_reg;
    logic signed [16:0] diff;
    logic signed [33:0] ip_prod;
    logic signed [17:0] interp_full;
    logic signed [15:0] s_reg;

    // Gains.
    logic [31:0] g1_sum;
    logic [16:0] g1_reg;
    logic [32:0] g2_sum;
    logic [17:0] g2_reg;
    logic [15:0] pan_eff;
    logic [15:0] lp;
    logic [32:0] gl_sum;
    logic [32:0] gr_sum;
    logic [17:0] gl_reg;
    logic [17:0] gr_reg;

    // Output scaling.
    logic signed [35:0] sl_sum;
    logic signed [35:0] sr_sum;
    logic signed [15:0] left_reg;
    logic signed [15:0] right_reg;

    // Position update.
    logic [32:0] fwd_sum;
    logic        fwd_stop;
    logic [31:0] fwd_pos;
    logic [32:0] bwd_diff;
    logic        bwd_neg;
    logic        bwd_stop;
    logic [31:0] bwd_pos;

    spv_pkg::res_item_t res_reg;

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            start_reg    <= '0;
            end_reg      <= '0;
            step_reg     <= spv_pkg::STEP_SIZE_RST;
            backward_reg <= 1'b0;
            level_reg    <= spv_pkg::OUTPUT_LEVEL_RST;
            pan_reg      <= spv_pkg::PAN_POSITION_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                spv_pkg::CFG_SAMPLE_COUNT:  count_reg    <= cfg_wdata[16:0];
                spv_pkg::CFG_START_INDEX:   start_reg    <= cfg_wdata[15:0];
                spv_pkg::CFG_END_INDEX:     end_reg      <= cfg_wdata[15:0];
                spv_pkg::CFG_STEP_SIZE:     step_reg     <= cfg_wdata[23:0];
                spv_pkg::CFG_PLAY_BACKWARD: backward_reg <= cfg_wdata[0];
                spv_pkg::CFG_OUTPUT_LEVEL:  level_reg    <= cfg_wdata[15:0];
                spv_pkg::CFG_PAN_POSITION:  pan_reg      <= cfg_wdata[15:0];
                default:                    ;
            endcase
        end
    end

    // A tick does real work only while playing with a non-empty sample.
    assign dp_stat.tick_live = (cmd_data.opcode == spv_pkg::OP_TICK) && playing_reg
                               && (count_reg != 17'd0);

    // Request capture.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
        end
        else if (dp_cmd.capture)
        begin
            live_reg <= dp_stat.tick_live;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            op_reg      <= cmd_data.opcode;
            waddr_reg   <= cmd_data.write_address;
            wsample_reg <= cmd_data.write_sample;
            vel_in_reg  <= cmd_data.note_velocity;
            env_reg     <= cmd_data.envelope_value;
        end
    end

    // Clamp the read index to the last valid sample.
    assign count_ext = {15'd0, count_reg};
    assign count_eff = (count_ext > DEPTH_W) ? DEPTH_W : count_ext;
    assign last_w    = count_eff - 32'd1;
    assign last_idx  = last_w[15:0];
    assign idx_raw   = pos_reg[31:16];
    assign beyond    = {16'd0, idx_raw} > last_w;
    assign rd_idx    = beyond ? last_idx : idx_raw;
    assign rd_frac   = beyond ? 16'd0 : pos_reg[15:0];

    // Memory addresses: first neighbor, then the one after it.
    assign addr_a_w = {16'd0, rd_idx};
    assign addr_b_w = {16'd0, idx_reg} + 32'd1;
    assign rd_addr  = dp_cmd.read_a ? addr_a_w[AW-1:0] : addr_b_w[AW-1:0];

    assign wr_addr_w = {16'd0, waddr_reg};
    assign wr_ok     = wr_addr_w < DEPTH_W;
    assign wr_addr   = wr_addr_w[AW-1:0];

    // Single-port sample memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sample_mem[wr_addr] <= wsample_reg;
        end
        if (dp_cmd.read_a || dp_cmd.read_b)
        begin
            rd_data_reg <= sample_mem[rd_addr];
        end
    end

    // Gain products, rounded back to Q1.15 after each multiply.
    assign g1_sum  = 32'(env_reg) * 32'(vel_hold_reg) + 32'd16384;
    assign g2_sum  = 33'(g1_reg) * 33'(level_reg) + 33'd16384;
    assign pan_eff = (pan_reg > spv_pkg::UNITY_Q15) ? spv_pkg::UNITY_Q15 : pan_reg;
    assign lp      = spv_pkg::UNITY_Q15 - pan_eff;
    assign gl_sum  = 33'(g2_reg) * 33'(lp) + 33'd16384;
    assign gr_sum  = 33'(g2_reg) * 33'(pan_eff) + 33'd16384;

    // Linear interpolation between the two neighbors, rounded toward minus infinity.
    assign diff        = {rd_data_reg[15], rd_data_reg} - {a_reg[15], a_reg};
    assign ip_prod     = diff * $signed({1'b0, frac_reg});
    assign interp_full = {{2{a_reg[15]}}, a_reg} + ip_prod[33:16];

    // Final scaling with rounding and floor shift.
    assign sl_sum = s_reg * $signed({1'b0, gl_reg}) + 36'sd16384;
    assign sr_sum = s_reg * $signed({1'b0, gr_reg}) + 36'sd16384;

    // Arithmetic stages, one per controller step.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.read_a)
        begin
            idx_reg     <= rd_idx;
            frac_reg    <= rd_frac;
            at_last_reg <= ({16'd0, rd_idx} == last_w);
            g1_reg      <= g1_sum[31:15];
        end
        if (dp_cmd.read_b)
        begin
            a_reg  <= rd_data_reg;
            g2_reg <= g2_sum[32:15];
        end
        if (dp_cmd.interp)
        begin
            s_reg  <= at_last_reg ? a_reg : interp_full[15:0];
            gl_reg <= gl_sum[32:15];
            gr_reg <= gr_sum[32:15];
        end
        if (dp_cmd.scale)
        begin
            left_reg  <= sat16(sl_sum[35:15]);
            right_reg <= sat16(sr_sum[35:15]);
        end
    end

    // Next position in either direction, saturated to 32 bits.
    assign fwd_sum  = {1'b0, pos_reg} + {9'd0, step_reg};
    assign fwd_stop = fwd_sum >= {1'b0, end_reg, 16'd0};
    assign fwd_pos  = fwd_sum[32] ? 32'hFFFF_FFFF : fwd_sum[31:0];
    assign bwd_diff = {1'b0, pos_reg} - {9'd0, step_reg};
    assign bwd_neg  = bwd_diff[32];
    assign bwd_stop = bwd_neg || (bwd_diff[31:0] <= {start_reg, 16'd0});
    assign bwd_pos  = bwd_neg ? 32'd0 : bwd_diff[31:0];

    // Request effects, applied when the result is committed.
    always_comb
    begin
        pos_next     = pos_reg;
        playing_next = playing_reg;
        vel_next     = vel_hold_reg;
        mem_we       = 1'b0;
        if (dp_cmd.commit)
        begin
            case (op_reg)
                spv_pkg::OP_WRITE:
                begin
                    mem_we = wr_ok;
                end
                spv_pkg::OP_NOTE_ON:
                begin
                    vel_next     = vel_in_reg;
                    pos_next     = {(backward_reg ? end_reg : start_reg), 16'd0};
                    playing_next = 1'b1;
                end
                spv_pkg::OP_NOTE_OFF:
                begin
                    playing_next = 1'b0;
                end
                spv_pkg::OP_TICK:
                begin
                    if (live_reg)
                    begin
                        if (backward_reg)
                        begin
                            pos_next = bwd_pos;
                            if (bwd_stop)
                                playing_next = 1'b0;
                        end
                        else
                        begin
                            pos_next = fwd_pos;
                            if (fwd_stop)
                                playing_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
        end
    end

    // Voice state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            playing_reg  <= 1'b0;
            vel_hold_reg <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            playing_reg  <= playing_next;
            vel_hold_reg <= vel_next;
        end
    end

    // Result register; outputs are zero unless a live tick ran.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.commit)
        begin
            res_reg.left_out     <= live_reg ? left_reg : 16'sd0;
            res_reg.right_out    <= live_reg ? right_reg : 16'sd0;
            res_reg.voice_active <= playing_next;
        end
    end

    assign res_data = res_reg;

endmodule

@@ test/sample_playback_voice_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sample_playback_voice_checker
// Watches the request, result and register ports of the voice core, keeps its
// own copy of the voice state and sample memory, predicts every result and
// compares it field by field with what the core returns.
// ----------------------------------------------------------------------------
module sample_playback_voice_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  logic                           cmd_stall,
    input  spv_pkg::cmd_item_t             cmd_data,
    input  logic                           res_valid,
    input  logic                           res_stall,
    input  spv_pkg::res_item_t             res_data,
    input  logic                           cfg_wr_en,
    input  logic [spv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [spv_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             mismatch_count,
    output int                             pending_results,
    output int                             audible_ticks
);

    import spv_pkg::*;

    localparam int DEPTH = SAMPLE_DEPTH_DEF;

    // Mirror of the sample memory and the voice state.
    logic signed [15:0] sample_mirror [0:DEPTH-1];
    logic [31:0]        play_pos;
    logic               playing;
    logic [15:0]        held_vel;

    // Mirror of the configuration registers.
    logic [16:0] reg_count;
    logic [15:0] reg_start;
    logic [15:0] reg_end;
    logic [23:0] reg_step;
    logic        reg_backward;
    logic [15:0] reg_level;
    logic [15:0] reg_pan;

    res_item_t expected_outputs [$];
    res_item_t prediction;
    res_item_t oldest;

    // Saturate a wide value to a signed 16-bit sample.
    function automatic logic signed [15:0] clip16(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // Apply one request to the mirrored state and work out its result.
    task automatic predict_voice(input cmd_item_t req, output res_item_t res);
        longint      a;
        longint      b;
        longint      frac;
        longint      interp;
        longint      env;
        longint      vel;
        longint      g1;
        longint      g2;
        longint      pan_eff;
        longint      gl;
        longint      gr;
        longint      cur;
        longint      stride;
        longint      limit;
        longint      nxt;
        longint      left;
        longint      right;
        int unsigned last;
        int unsigned idx;
        logic [31:0] pos;

        left  = 0;
        right = 0;
        case (req.opcode)
            OP_WRITE:
            begin
                if (int'(req.write_address) < DEPTH)
                    sample_mirror[req.write_address] = req.write_sample;
            end
            OP_NOTE_ON:
            begin
                held_vel = req.note_velocity;
                play_pos = {(reg_backward ? reg_end : reg_start), 16'h0000};
                playing  = 1'b1;
            end
            OP_NOTE_OFF:
            begin
                playing = 1'b0;
            end
            default:
            begin
                if (playing && reg_count != 0)
                begin
                    // Clamp the read position to the last valid sample.
                    last = ((int'(reg_count) > DEPTH) ? DEPTH : int'(reg_count)) - 1;
                    pos  = play_pos;
                    if (32'(pos[31:16]) > last)
                        pos = {last[15:0], 16'h0000};
                    idx  = 32'(pos[31:16]);
                    frac = longint'(pos[15:0]);
                    a    = longint'(sample_mirror[idx]);
                    if (idx < last)
                    begin
                        b      = longint'(sample_mirror[idx + 1]);
                        interp = a + (((b - a) * frac) >>> 16);
                    end
                    else
                    begin
                        interp = a;
                    end

                    // Gain chain: envelope, velocity, level, then pan split.
                    env     = longint'(req.envelope_value);
                    vel     = longint'(held_vel);
                    g1      = (env * vel + 16384) >>> 15;
                    g2      = (g1 * longint'(reg_level) + 16384) >>> 15;
                    pan_eff = (reg_pan > 16'd32768) ? 32768 : longint'(reg_pan);
                    gl      = (g2 * (32768 - pan_eff) + 16384) >>> 15;
                    gr      = (g2 * pan_eff + 16384) >>> 15;
                    left    = clip16((interp * gl + 16384) >>> 15);
                    right   = clip16((interp * gr + 16384) >>> 15);

                    // Advance the position and test the end point.
                    cur    = longint'(play_pos);
                    stride = longint'(reg_step);
                    if (reg_backward)
                    begin
                        limit = longint'(reg_start) << 16;
                        nxt   = cur - stride;
                        if (nxt <= limit)
                            playing = 1'b0;
                    end
                    else
                    begin
                        limit = longint'(reg_end) << 16;
                        nxt   = cur + stride;
                        if (nxt >= limit)
                            playing = 1'b0;
                    end
                    if (nxt < 0)
                        nxt = 0;
                    if (nxt > 64'h0000_0000_FFFF_FFFF)
                        nxt = 64'h0000_0000_FFFF_FFFF;
                    play_pos = nxt[31:0];
                    audible_ticks++;
                end
            end
        endcase
        res.left_out     = left[15:0];
        res.right_out    = right[15:0];
        res.voice_active = playing;
    endtask

    // Results are checked before new requests are predicted at the same edge.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            play_pos       = '0;
            playing        = 1'b0;
            held_vel       = '0;
            reg_count      = '0;
            reg_start      = '0;
            reg_end        = '0;
            reg_step       = STEP_SIZE_RST;
            reg_backward   = 1'b0;
            reg_level      = OUTPUT_LEVEL_RST;
            reg_pan        = PAN_POSITION_RST;
            mismatch_count = 0;
            audible_ticks  = 0;
            expected_outputs.delete();
        end
        else
        begin
            // Compare an accepted result with the oldest prediction.
            if (res_valid && !res_stall)
            begin
                if (expected_outputs.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result expected none, got left %0d right %0d active %0b",
                             $time, res_data.left_out, res_data.right_out,
                             res_data.voice_active);
                end
                else
                begin
                    oldest = expected_outputs.pop_front();
                    if (res_data.left_out !== oldest.left_out)
                    begin
                        mismatch_count++;
                        $display("%0t: left_out expected %0d got %0d",
                                 $time, oldest.left_out, res_data.left_out);
                    end
                    if (res_data.right_out !== oldest.right_out)
                    begin
                        mismatch_count++;
                        $display("%0t: right_out expected %0d got %0d",
                                 $time, oldest.right_out, res_data.right_out);
                    end
                    if (res_data.voice_active !== oldest.voice_active)
                    begin
                        mismatch_count++;
                        $display("%0t: voice_active expected %0b got %0b",
                                 $time, oldest.voice_active, res_data.voice_active);
                    end
                end
            end

            // Track register writes.
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_SAMPLE_COUNT:  reg_count    = cfg_wdata[16:0];
                    CFG_START_INDEX:   reg_start    = cfg_wdata[15:0];
                    CFG_END_INDEX:     reg_end      = cfg_wdata[15:0];
                    CFG_STEP_SIZE:     reg_step     = cfg_wdata[23:0];
                    CFG_PLAY_BACKWARD: reg_backward = cfg_wdata[0];
                    CFG_OUTPUT_LEVEL:  reg_level    = cfg_wdata[15:0];
                    CFG_PAN_POSITION:  reg_pan      = cfg_wdata[15:0];
                    default: ;
                endcase
            end

            // Predict the result of an accepted request.
            if (cmd_valid && !cmd_stall)
            begin
                predict_voice(cmd_data, prediction);
                expected_outputs.push_back(prediction);
            end
        end
        pending_results = expected_outputs.size();
    end

endmodule

@@ test/sample_playback_voice_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sample_playback_voice_core_tb
// Drives the voice core through a series of register settings with directed
// and random request streams, under random sender gaps and receiver stalls.
// The checker beside the core predicts and compares; this module decides.
// ----------------------------------------------------------------------------
module sample_playback_voice_core_tb;

    import spv_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DEPTH          = SAMPLE_DEPTH_DEF;
    localparam int RANDOM_BUDGET  = 1700;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cmd_valid = 1'b0;
    logic                  cmd_stall;
    cmd_item_t             cmd_data  = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    res_item_t             res_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int mismatch_count;
    int pending_results;
    int audible_ticks;
    int request_count  = 0;
    int settings_count = 0;
    int burst_left     = 0;
    int idle_cycles    = 0;

    // Entries that hold a defined value, and the current playback window.
    bit          sample_written [0:DEPTH-1];
    int unsigned cur_start = 0;
    int unsigned cur_end   = 0;

    // Receiver stall pattern state.
    int         stall_mode = 0;
    int         mode_left  = 0;
    int         stall_run  = 0;
    logic [7:0] stall_mask = 8'h5A;
    logic       stall_next;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sample_playback_voice_core #(
        .SAMPLE_DEPTH (DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    sample_playback_voice_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_stall       (cmd_stall),
        .cmd_data        (cmd_data),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .res_data        (res_data),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .audible_ticks   (audible_ticks)
    );

    // Receiver stalls: the mode is drawn at random for a random stretch among
    // no stalls, random stalls, long stall runs and a rotating bit pattern.
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(50, 300);
            stall_mask = 8'($urandom) & 8'hEF;
        end
        else
        begin
            mode_left--;
        end
        case (stall_mode)
            0: stall_next = 1'b0;
            1: stall_next = ($urandom_range(0, 99) < 35);
            2:
            begin
                if (stall_run > 0)
                begin
                    stall_run--;
                    stall_next = 1'b1;
                end
                else
                begin
                    stall_next = 1'b0;
                    if ($urandom_range(0, 19) == 0)
                        stall_run = $urandom_range(1, 25);
                end
            end
            default:
            begin
                stall_mask = {stall_mask[6:0], stall_mask[7]};
                stall_next = stall_mask[0];
            end
        endcase
        res_stall <= stall_next;
    end

    // Watchdog: too many cycles in a row with no request or result accepted ends the run.
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("sample_playback_voice_core: mismatch");
            $finish;
        end
    end

    // Gains favor the Q1.15 range but also reach every 16-bit code.
    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return UNITY_Q15;
            2:       return 16'hFFFF;
            3:       return 16'($urandom);
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    // A request with the given opcode and random content in every field.
    function automatic cmd_item_t random_request(input opcode_t op);
        cmd_item_t req;
        req.opcode         = op;
        req.write_address  = 16'($urandom);
        req.write_sample   = 16'($urandom);
        req.note_velocity  = pick_gain();
        req.envelope_value = pick_gain();
        return req;
    endfunction

    // An address mostly inside the current playback window.
    function automatic logic [15:0] near_address();
        int unsigned lo;
        int unsigned hi;
        lo = (cur_start < cur_end) ? cur_start : cur_end;
        hi = ((cur_start > cur_end) ? cur_start : cur_end) + 2;
        if (hi > DEPTH - 1)
            hi = DEPTH - 1;
        if ($urandom_range(0, 9) < 7)
            return 16'($urandom_range(hi, lo));
        return 16'($urandom);
    endfunction

    // Send one request; the sender works in bursts separated by random gaps.
    task automatic send_request(input cmd_item_t req);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 20);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        cmd_valid <= 1'b1;
        cmd_data  <= req;
        burst_left--;
        request_count++;
        if (req.opcode == OP_WRITE)
            sample_written[req.write_address] = 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic drain_results();
        @(negedge clk);
        cmd_valid <= 1'b0;
        burst_left = 0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
    endtask

    // Write a random value to an entry that has never been written.
    task automatic load_if_blank(input int unsigned addr);
        cmd_item_t req;
        if (!sample_written[addr])
        begin
            req               = random_request(OP_WRITE);
            req.write_address = addr[15:0];
            send_request(req);
        end
    endtask

    // Reprogram every register while idle, then make sure that every sample
    // a note can read under the new window holds a defined value.
    task automatic apply_settings(input int unsigned count, input int unsigned start,
                                  input int unsigned stop, input int unsigned step,
                                  input int unsigned backward, input int unsigned level,
                                  input int unsigned pan);
        int unsigned last;
        int unsigned lo;
        int unsigned hi;
        drain_results();
        write_register(CFG_SAMPLE_COUNT, count);
        write_register(CFG_START_INDEX, start);
        write_register(CFG_END_INDEX, stop);
        write_register(CFG_STEP_SIZE, step);
        write_register(CFG_PLAY_BACKWARD, backward);
        write_register(CFG_OUTPUT_LEVEL, level);
        write_register(CFG_PAN_POSITION, pan);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        settings_count++;
        cur_start = start;
        cur_end   = stop;
        if (count != 0)
        begin
            last = ((count > DEPTH) ? DEPTH : count) - 1;
            lo   = (start < stop) ? start : stop;
            hi   = ((start > stop) ? start : stop) + 1;
            if (hi > last)
                hi = last;
            for (int unsigned i = lo; i <= hi; i++)
                load_if_blank(i);
            load_if_blank(last);
        end
    endtask

    // Random traffic: mostly notes with runs of ticks, some writes into the
    // playback window, some noise, and now and then a full drain.
    task automatic play_random(input int n);
        int        sent;
        int        r;
        int        ticks;
        cmd_item_t req;
        sent = 0;
        while (sent < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
            begin
                send_request(random_request(OP_NOTE_ON));
                sent++;
                ticks = $urandom_range(1, 40);
                repeat (ticks)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        req               = random_request(OP_WRITE);
                        req.write_address = near_address();
                        send_request(req);
                        sent++;
                    end
                    send_request(random_request(OP_TICK));
                    sent++;
                end
                if ($urandom_range(0, 9) < 6)
                begin
                    send_request(random_request(OP_NOTE_OFF));
                    sent++;
                end
            end
            else if (r < 80)
            begin
                req               = random_request(OP_WRITE);
                req.write_address = near_address();
                send_request(req);
                sent++;
            end
            else if (r < 97)
            begin
                send_request(random_request(opcode_t'($urandom_range(0, 3))));
                sent++;
            end
            else
            begin
                drain_results();
            end
        end
    endtask

    // One register setting with random traffic, ending with the voice off.
    task automatic run_phase(input int unsigned count, input int unsigned start,
                             input int unsigned stop, input int unsigned step,
                             input int unsigned backward, input int unsigned level,
                             input int unsigned pan, input int n);
        apply_settings(count, start, stop, step, backward, level, pan);
        play_random(n);
        send_request(random_request(OP_NOTE_OFF));
    endtask

    // Directed opening: idle requests, full-scale samples, extreme gains,
    // and one note that runs forward to its end point with fractional steps.
    task automatic directed_opening();
        cmd_item_t req;
        send_request(random_request(OP_TICK));
        send_request(random_request(OP_NOTE_OFF));
        req = random_request(OP_WRITE);
        req.write_address = 16'hFFFF;
        req.write_sample  = 16'sh8000;
        send_request(req);
        req = random_request(OP_WRITE);
        req.write_address = 16'd0;
        req.write_sample  = 16'sh7FFF;
        send_request(req);
        req = random_request(OP_WRITE);
        req.write_address = 16'd2;
        req.write_sample  = 16'sh7FFF;
        send_request(req);
        req = random_request(OP_WRITE);
        req.write_address = 16'd3;
        req.write_sample  = 16'sh8000;
        send_request(req);
        req = random_request(OP_NOTE_ON);
        req.note_velocity = UNITY_Q15;
        send_request(req);
        req = random_request(OP_TICK);
        req.envelope_value = UNITY_Q15;
        send_request(req);
        req.envelope_value = 16'hFFFF;
        send_request(req);
        req.envelope_value = 16'd0;
        send_request(req);
        req = random_request(OP_NOTE_ON);
        req.note_velocity = 16'd0;
        send_request(req);
        req = random_request(OP_TICK);
        req.envelope_value = UNITY_Q15;
        send_request(req);
        req = random_request(OP_NOTE_ON);
        req.note_velocity = 16'hFFFF;
        send_request(req);
        req = random_request(OP_TICK);
        req.envelope_value = 16'hFFFF;
        send_request(req);
        send_request(random_request(OP_NOTE_OFF));
        send_request(random_request(OP_TICK));
        req = random_request(OP_NOTE_ON);
        req.note_velocity = UNITY_Q15;
        send_request(req);
        repeat (5)
            send_request(random_request(OP_TICK));
        send_request(random_request(OP_NOTE_OFF));
    endtask

    // Main sequence.
    initial
    begin
        int unsigned count;
        int unsigned start;
        int          stop;
        int unsigned step;
        int unsigned level;
        int unsigned pan;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        apply_settings(16, 2, 12, 32'h28000, 0, 32768, 16384);
        directed_opening();

        // Fixed settings aimed at the corners of the playback logic.
        run_phase(256, 10, 200, 32'h2000, 0, 32768, 16384, 70);
        run_phase(256, 10, 200, 32'h2000, 1, 32768, 16384, 70);
        // Empty memory: ticks stay silent and the voice keeps its state.
        run_phase(0, 0, 5, 32'h10000, 0, 32768, 16384, 30);
        run_phase(65536, 65500, 65535, 32'h10000, 0, 0, 0, 60);
        // Count above the memory depth, pan and level above unity, and a
        // forward step that pushes the position past 32 bits.
        run_phase(131071, 65400, 65535, 32'hFFFFFF, 0, 65535, 65535, 60);
        run_phase(65536, 65400, 65535, 32'hFFFFFF, 1, 32768, 32768, 50);
        // Windows that run past the last sample, so reads are clamped.
        run_phase(40, 30, 100, 32'h18000, 0, 32768, 32768, 65);
        run_phase(40, 50, 60, 32'h8000, 1, 20000, 5000, 60);
        // Backward step that falls below zero.
        run_phase(8, 0, 3, 32'hFFFFFF, 1, 32768, 16384, 40);
        // Zero step: only a note-off ends the note.
        run_phase(100, 20, 80, 0, 0, 32768, 16384, 50);
        // Start beyond end going forward: the note ends on its first tick.
        run_phase(128, 90, 20, 32'h10000, 0, 32768, 16384, 40);

        // Random settings until the request budget is spent.
        while (request_count < RANDOM_BUDGET)
        begin
            count = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 1024);
            start = $urandom_range(0, count + 16);
            stop  = int'(start) + $urandom_range(0, 300) - 60;
            if (stop < 0)
                stop = 0;
            if (stop > DEPTH - 1)
                stop = DEPTH - 1;
            case ($urandom_range(0, 9))
                0:       step = 32'hFFFFFF;
                1:       step = 0;
                default: step = $urandom_range(1, 32'h30000);
            endcase
            level = ($urandom_range(0, 4) == 0) ? ($urandom & 32'hFFFF)
                                                : $urandom_range(0, 32768);
            pan   = ($urandom_range(0, 4) == 0) ? ($urandom & 32'hFFFF)
                                                : $urandom_range(0, 32768);
            run_phase(count, start, stop, step, $urandom_range(0, 1), level, pan, 60);
        end

        // Back to the reset values of the gain and step registers.
        run_phase(300, 0, 299, STEP_SIZE_RST, 0, OUTPUT_LEVEL_RST, PAN_POSITION_RST, 70);

        drain_results();
        repeat (20) @(negedge clk);

        $display("Covered %0d requests under %0d register settings, %0d ticks with sound.",
                 request_count, settings_count, audible_ticks);
        $display("Notes ran both ways, with clamped reads, empty memory and saturation.");
        if (mismatch_count == 0)
            $display("sample_playback_voice_core: match");
        else
            $display("sample_playback_voice_core: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/spv_pkg.sv
rtl/core/spv_ctrl.sv
rtl/core/spv_datapath.sv
rtl/core/sample_playback_voice_core.sv
test/sample_playback_voice_checker.sv
test/sample_playback_voice_core_tb.sv
